// ===== rtl/smeu_pkg.sv =====
package smeu_pkg;

    localparam int StackDepth = 1024;
    localparam int IdxW = $clog2(StackDepth);
    localparam int ClearCycles = StackDepth;

    typedef enum logic [4:0] {
        OP_HALT  = 5'd0,
        OP_LOAD  = 5'd1,
        OP_PUSH  = 5'd2,
        OP_POP   = 5'd3,
        OP_GET   = 5'd4,
        OP_PUT   = 5'd5,
        OP_JMP   = 5'd6,
        OP_JMPIF = 5'd7,
        OP_OUT   = 5'd8,
        OP_ADD   = 5'd9,
        OP_SUB   = 5'd10,
        OP_MUL   = 5'd11,
        OP_DIV   = 5'd12,
        OP_MOD   = 5'd13,
        OP_EQ    = 5'd14,
        OP_LESS  = 5'd15,
        OP_LOR   = 5'd16,
        OP_LAND  = 5'd17,
        OP_NOT   = 5'd18
    } t_op;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [2:0] ERR_INDEX     = 3'd3;
    localparam logic [2:0] ERR_DIVZERO   = 3'd4;
    localparam logic [2:0] ERR_HALTED    = 3'd5;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [31:0] immediate;
    } t_in;

    typedef struct packed {
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               jump_taken;
        logic signed [31:0] jump_offset;
        logic [2:0]         error_code;
        logic               halted;
    } t_out;

endpackage

// ===== rtl/stack_machine_execute_unit_top.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_in  (op, immediate)
// out     | output    | o_out_valid / i_out_stall | o_out (print, jump, error, halted)
//
// Reset runs a clearing pass over all StackDepth (1024) entries of the stack RAM; input stalls.
// Typical instruction, from transfer to transfer: accept, two reads on the single
// RAM read port (top, second), execute with write back, load of the output register.
// GET adds an indexed read and a write back; DIV and MOD add the divider run and a write.
// A halted machine goes from accept straight to the output load. The next transfer in is taken while a result
// waits in the output register; only the load of a new result waits for it to leave.
module stack_machine_execute_unit_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  smeu_pkg::t_in i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output smeu_pkg::t_out o_out
);
    import smeu_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_GETRD, S_GETWR, S_DIV, S_DIVWR, S_EMIT
    } t_state;

    t_state             r_state;
    logic [IdxW-1:0]    r_top, r_clr;
    logic               r_stop;
    logic [4:0]         r_op;
    logic [31:0]        r_imm, r_topv, r_below, r_res;
    t_out               r_pend;

    // memory port
    logic               n_we;
    logic [IdxW-1:0]    n_waddr, n_raddr;
    logic [31:0]        n_wdata, w_rdata;

    logic               w_dstart, w_ddone;
    logic [31:0]        w_quo, w_rem;

    smeu_ram #(.Width(32), .Depth(StackDepth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (n_raddr),
        .o_rdata (w_rdata)
    );

    smeu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_a     (r_below),
        .i_b     (r_topv),
        .o_done  (w_ddone),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_dstart   = (r_state == S_EXEC) && !r_stop_err();

    // relative index: top - signed offset, must be in range
    logic signed [33:0] w_rel;
    logic               w_rel_ok;
    logic [31:0]        w_off;
    assign w_off    = (r_op == OP_GET) ? r_topv : r_below;
    assign w_rel    = $signed({24'd0, r_top}) - $signed({{2{w_off[31]}}, w_off});
    assign w_rel_ok = (w_rel >= 0) && (w_rel < StackDepth);

    logic [2:0] w_err;
    always_comb begin
        w_err = ERR_NONE;
        if ((r_op == OP_PUT || r_op == OP_JMPIF || (r_op >= OP_ADD && r_op <= OP_LAND))
            && r_top == '0) begin
            w_err = ERR_UNDERFLOW;
        end else begin
            case (r_op)
                OP_PUSH: if (r_top == IdxW'(StackDepth - 1)) w_err = ERR_OVERFLOW;
                OP_POP:  if (r_top == '0) w_err = ERR_UNDERFLOW;
                OP_GET, OP_PUT: if (!w_rel_ok) w_err = ERR_INDEX;
                OP_DIV, OP_MOD: if (r_topv == '0) w_err = ERR_DIVZERO;
                default: ;
            endcase
        end
    end

    function automatic logic r_stop_err();
        return (w_err != ERR_NONE) || !(r_op == OP_DIV || r_op == OP_MOD);
    endfunction

    logic [63:0] w_prod;
    assign w_prod = r_below * r_topv;

    // Write value for simple ops, computed in S_EXEC.
    logic [31:0] w_alu;
    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_below + r_topv;
            OP_SUB:  w_alu = r_below - r_topv;
            OP_MUL:  w_alu = w_prod[31:0];
            OP_EQ:   w_alu = {31'd0, r_below == r_topv};
            OP_LESS: w_alu = {31'd0, $signed(r_below) < $signed(r_topv)};
            OP_LOR:  w_alu = {31'd0, (r_below != 0) || (r_topv != 0)};
            OP_LAND: w_alu = {31'd0, (r_below != 0) && (r_topv != 0)};
            OP_NOT:  w_alu = {31'd0, r_topv == 0};
            OP_LOAD: w_alu = r_imm;
            default: w_alu = r_topv;
        endcase
    end

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_top;
        n_wdata = w_alu;
        n_raddr = r_top;
        unique case (r_state)
            S_CLEAR: begin
                n_we = 1'b1; n_waddr = r_clr; n_wdata = '0;
            end
            S_IDLE: n_raddr = r_top;
            S_RD1:  n_raddr = r_top - IdxW'(1);
            S_EXEC: begin
                n_raddr = w_rel[IdxW-1:0];
                if (w_err == ERR_NONE) begin
                    case (r_op)
                        OP_LOAD, OP_NOT: n_we = 1'b1;
                        OP_PUT: begin
                            n_we = 1'b1; n_waddr = w_rel[IdxW-1:0]; n_wdata = r_topv;
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_LESS, OP_LOR, OP_LAND: begin
                            n_we = 1'b1; n_waddr = r_top - IdxW'(1);
                        end
                        default: ;
                    endcase
                end
            end
            // hold the indexed address so the read data stays for the write back
            S_GETRD: n_raddr = w_rel[IdxW-1:0];
            S_GETWR: begin
                n_we = 1'b1; n_wdata = w_rdata;
            end
            S_DIVWR: begin
                n_we = 1'b1; n_waddr = r_top - IdxW'(1); n_wdata = r_res;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_top       <= '0;
            r_stop      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_EMIT) o_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IdxW'(1);
                    if (r_clr == IdxW'(ClearCycles - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_op  <= i_in.op;
                        r_imm <= i_in.immediate;
                        if (r_stop) begin
                            r_pend <= '{print_valid: 1'b0, print_value: '0,
                                        jump_taken: 1'b0, jump_offset: '0,
                                        error_code: ERR_HALTED, halted: 1'b1};
                            r_state <= S_EMIT;
                        end else begin
                            r_pend  <= '0;
                            r_state <= S_RD1;
                        end
                    end
                end
                S_RD1: begin
                    r_topv  <= w_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_below <= (r_top == '0) ? 32'd0 : w_rdata;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_pend.error_code <= w_err;
                    if (w_err != ERR_NONE) begin
                        r_stop <= 1'b1;
                        r_pend.halted <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        if (r_op == OP_GET) r_state <= S_GETRD;
                        else if (r_op == OP_DIV || r_op == OP_MOD) r_state <= S_DIV;
                        else r_state <= S_EMIT;
                        case (r_op)
                            OP_HALT: begin
                                r_stop <= 1'b1; r_pend.halted <= 1'b1;
                            end
                            OP_PUSH: r_top <= r_top + IdxW'(1);
                            OP_POP:  r_top <= r_top - IdxW'(1);
                            OP_JMP: begin
                                r_pend.jump_taken <= 1'b1; r_pend.jump_offset <= r_topv;
                            end
                            OP_JMPIF: if (r_below != 0) begin
                                r_pend.jump_taken <= 1'b1; r_pend.jump_offset <= r_topv;
                            end
                            OP_OUT: begin
                                r_pend.print_valid <= 1'b1; r_pend.print_value <= r_topv;
                            end
                            default: ;
                        endcase
                    end
                end
                S_GETRD: r_state <= S_GETWR;
                S_GETWR: r_state <= S_EMIT;
                S_DIV: begin
                    if (w_ddone) begin
                        r_res   <= (r_op == OP_DIV) ? w_quo : w_rem;
                        r_state <= S_DIVWR;
                    end
                end
                S_DIVWR: r_state <= S_EMIT;
                S_EMIT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out       <= r_pend;
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/smeu_ram.sv =====
module smeu_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/smeu_div.sv =====
// Signed restoring divider, one quotient bit per cycle.
module smeu_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic [31:0]        o_quo,
    output logic [31:0]        o_rem
);
    logic [31:0] r_q, r_d;
    logic [32:0] r_r;
    logic [5:0]  r_cnt;
    logic        r_busy, r_nq, r_nr;
    logic [32:0] n_sh;
    logic [32:0] n_df;

    assign n_sh = {r_r[31:0], r_q[31]};
    assign n_df = n_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_q    <= i_a[31] ? 32'(-i_a) : i_a;
                r_d    <= i_b[31] ? 32'(-i_b) : i_b;
                r_r    <= '0;
                r_nq   <= i_a[31] ^ i_b[31];
                r_nr   <= i_a[31];
            end else if (r_busy) begin
                if (n_df[32]) begin
                    r_r <= n_sh;
                    r_q <= {r_q[30:0], 1'b0};
                end else begin
                    r_r <= n_df;
                    r_q <= {r_q[30:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_nq ? 32'(-r_q) : r_q;
    assign o_rem = r_nr ? 32'(-r_r[31:0]) : r_r[31:0];
endmodule

// ===== rtl/smeu_checker.sv =====
module smeu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input smeu_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input smeu_pkg::t_out o_out
);
    import smeu_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error_code != ERR_NONE |-> o_out.halted)
        else $error("error without halt");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.print_valid && o_out.jump_taken))
        else $error("print and jump together");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.error_code <= ERR_HALTED)
        else $error("bad error code");
endmodule

bind stack_machine_execute_unit_top smeu_checker u_smeu_checker (.*);
